[rtl/core/midpoint_ellipse_rasterizer_core_macros.svh]
// Assertion helpers shared by the rasterizer core.
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_CORE_MACROS_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_CORE_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define MER_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies another in the next cycle.
`define MER_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Check that a condition never holds.
`define MER_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error(msg);

`endif

[rtl/core/mer_pkg.sv]
package mer_pkg;

   // Field widths
   localparam int COORD_BITS  = 16;
   localparam int RADIUS_BITS = 12;
   localparam int OUT_BITS    = COORD_BITS + 1;
   localparam int OFFS_BITS   = RADIUS_BITS + 1;
   localparam int SQ_BITS     = 2 * RADIUS_BITS;
   localparam int KDIFF_BITS  = SQ_BITS + 3;
   localparam int STEP_BITS   = 3 * RADIUS_BITS + 2;
   localparam int DEC_BITS    = 3 * RADIUS_BITS + 8;

   // Stream packing
   localparam int REQ_FIELD_BITS = 2 * COORD_BITS + 2 * RADIUS_BITS + 1;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = 3 * OUT_BITS + 1;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS   = RSP_DATA_BITS - RSP_FIELD_BITS;

   // Point queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Input word kinds
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_STEP  = 1'b1;

   typedef enum logic [1:0] {
      RK_PIXEL = 2'd0,
      RK_SPAN  = 2'd1,
      RK_NONE  = 2'd2
   } result_kind_type;

   typedef enum logic [1:0] {
      REG_ONE      = 2'd0,
      REG_TWO      = 2'd1,
      REG_FINISHED = 2'd2
   } region_type;

   typedef enum logic [2:0] {
      FS_IDLE,
      FS_INIT_SQ,
      FS_INIT_DY,
      FS_INIT_D,
      FS_UPD_A,
      FS_UPD_B,
      FS_SETTLE,
      FS_PUSH
   } front_state_type;

   // One point to be drawn, as handed from front to back
   typedef struct packed {
      logic                          finished;
      logic                          done;
      logic                          fill;
      logic [OFFS_BITS-1:0]          off_x;
      logic signed [OFFS_BITS-1:0]   off_y;
      logic signed [COORD_BITS-1:0]  cen_x;
      logic signed [COORD_BITS-1:0]  cen_y;
   } point_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

[rtl/core/mer_front.sv]
module mer_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic                                kind,
   input  logic signed [mer_pkg::COORD_BITS-1:0] center_x,
   input  logic signed [mer_pkg::COORD_BITS-1:0] center_y,
   input  logic [mer_pkg::RADIUS_BITS-1:0]     radius_x,
   input  logic [mer_pkg::RADIUS_BITS-1:0]     radius_y,
   input  logic                                fill,
   input  mer_pkg::q_status_type               q_status,
   output logic                                push,
   output mer_pkg::point_type                  push_data
);
   import mer_pkg::*;

   front_state_type state_ff, state_in;
   region_type      region_ff, region_in;

   logic [OFFS_BITS-1:0]         off_x_ff, off_x_in;
   logic signed [OFFS_BITS-1:0]  off_y_ff, off_y_in;
   logic [SQ_BITS-1:0]           a_sq_ff, a_sq_in;
   logic [SQ_BITS-1:0]           b_sq_ff, b_sq_in;
   logic signed [KDIFF_BITS-1:0] kdiff_ff, kdiff_in;
   logic signed [STEP_BITS-1:0]  dx_ff, dx_in;
   logic signed [STEP_BITS-1:0]  dy_ff, dy_in;
   logic signed [DEC_BITS-1:0]   dec_ff, dec_in;
   logic signed [COORD_BITS-1:0] cen_x_ff, cen_x_in;
   logic signed [COORD_BITS-1:0] cen_y_ff, cen_y_in;
   logic                         fill_ff, fill_in;
   logic [RADIUS_BITS-1:0]       rad_x_ff, rad_x_in;
   logic [OFFS_BITS-1:0]         pt_x_ff, pt_x_in;
   logic signed [OFFS_BITS-1:0]  pt_y_ff, pt_y_in;
   logic                         cond_ff, cond_in;
   logic                         step_ff, step_in;
   logic                         fin_ff, fin_in;
   logic                         done_ff, done_in;

   logic [RADIUS_BITS-1:0]         rb;
   logic [SQ_BITS-1:0]             a_sq_prod, b_sq_prod;
   logic [SQ_BITS+RADIUS_BITS-1:0] dy_prod;
   logic signed [SQ_BITS:0]        sq_diff;
   logic signed [KDIFF_BITS-1:0]   sq_diff_w;
   logic signed [STEP_BITS-1:0]    two_a, two_b;
   logic signed [DEC_BITS-1:0]     a_w, b_w, dx_w, dy_w, k_w, t_sel;
   region_type                     reg_mid;
   logic                           done_sel;

   // Multipliers and widened operands
   always_comb begin
      rb        = off_y_ff[RADIUS_BITS-1:0];
      a_sq_prod = rad_x_ff * rad_x_ff;
      b_sq_prod = rb * rb;
      dy_prod   = a_sq_ff * rb;
      sq_diff   = signed'({1'b0, a_sq_ff}) - signed'({1'b0, b_sq_ff});
      sq_diff_w = KDIFF_BITS'(sq_diff);
      two_a     = STEP_BITS'(signed'({1'b0, a_sq_ff, 1'b0}));
      two_b     = STEP_BITS'(signed'({1'b0, b_sq_ff, 1'b0}));
      a_w       = DEC_BITS'(signed'({1'b0, a_sq_ff}));
      b_w       = DEC_BITS'(signed'({1'b0, b_sq_ff}));
      dx_w      = DEC_BITS'(dx_ff);
      dy_w      = DEC_BITS'(dy_ff);
      k_w       = DEC_BITS'(kdiff_ff);
   end

   // Sequencer: next state, datapath updates and queue push
   always_comb begin
      state_in  = state_ff;
      region_in = region_ff;
      off_x_in  = off_x_ff;
      off_y_in  = off_y_ff;
      a_sq_in   = a_sq_ff;
      b_sq_in   = b_sq_ff;
      kdiff_in  = kdiff_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      dec_in    = dec_ff;
      cen_x_in  = cen_x_ff;
      cen_y_in  = cen_y_ff;
      fill_in   = fill_ff;
      rad_x_in  = rad_x_ff;
      pt_x_in   = pt_x_ff;
      pt_y_in   = pt_y_ff;
      cond_in   = cond_ff;
      step_in   = step_ff;
      fin_in    = fin_ff;
      done_in   = done_ff;
      reg_mid   = region_ff;
      t_sel     = '0;
      done_sel  = done_ff;
      push      = 1'b0;
      in_ready  = (state_ff == FS_IDLE);

      unique case (state_ff)
         FS_IDLE: begin
            if (in_valid) begin
               if (kind == KIND_START) begin
                  cen_x_in = center_x;
                  cen_y_in = center_y;
                  fill_in  = fill;
                  rad_x_in = radius_x;
                  off_x_in = '0;
                  off_y_in = signed'({1'b0, radius_y});
                  dx_in    = '0;
                  step_in  = 1'b0;
                  state_in = FS_INIT_SQ;
               end else if (region_ff == REG_FINISHED) begin
                  fin_in   = 1'b1;
                  done_in  = 1'b1;
                  state_in = FS_PUSH;
               end else begin
                  fin_in   = 1'b0;
                  step_in  = 1'b1;
                  pt_x_in  = off_x_ff;
                  pt_y_in  = off_y_ff;
                  state_in = FS_UPD_A;
               end
            end
         end
         FS_INIT_SQ: begin
            a_sq_in  = a_sq_prod;
            b_sq_in  = b_sq_prod;
            state_in = FS_INIT_DY;
         end
         FS_INIT_DY: begin
            dy_in    = signed'({1'b0, dy_prod, 1'b0});
            kdiff_in = (sq_diff_w <<< 1) + sq_diff_w;
            state_in = FS_INIT_D;
         end
         FS_INIT_D: begin
            dec_in    = (b_w <<< 2) + a_w - (dy_w <<< 1);
            region_in = REG_ONE;
            state_in  = FS_SETTLE;
         end
         // Move the offsets and step terms
         FS_UPD_A: begin
            if (region_ff == REG_ONE) begin
               cond_in = (dec_ff > 0);
               if (dec_ff > 0) begin
                  off_y_in = off_y_ff - 1'b1;
                  dy_in    = dy_ff - two_a;
               end
               off_x_in = off_x_ff + 1'b1;
               dx_in    = dx_ff + two_b;
            end else begin
               cond_in = (dec_ff < 0);
               if (dec_ff < 0) begin
                  off_x_in = off_x_ff + 1'b1;
                  dx_in    = dx_ff + two_b;
               end
               off_y_in = off_y_ff - 1'b1;
               dy_in    = dy_ff - two_a;
            end
            state_in = FS_UPD_B;
         end
         // Fold the new step terms into the decision value
         FS_UPD_B: begin
            if (region_ff == REG_ONE) begin
               t_sel  = cond_ff ? (dy_w <<< 2) : '0;
               dec_in = dec_ff + ((b_w + dx_w) <<< 2) - t_sel;
            end else begin
               t_sel  = cond_ff ? (dx_w <<< 2) : '0;
               dec_in = dec_ff + t_sel + ((a_w - dy_w) <<< 2);
            end
            state_in = FS_SETTLE;
         end
         // Switch regions or finish, then hand the point on after a step word
         FS_SETTLE: begin
            if ((region_ff == REG_ONE) && !(dx_ff < dy_ff)) begin
               dec_in  = dec_ff + k_w - ((dx_w + dy_w) <<< 1);
               reg_mid = REG_TWO;
            end
            if ((reg_mid == REG_TWO) && (off_y_ff < 0)) begin
               reg_mid = REG_FINISHED;
            end
            region_in = reg_mid;
            done_sel  = (reg_mid == REG_FINISHED);
            done_in   = done_sel;
            if (!step_ff) begin
               state_in = FS_IDLE;
            end else if (!q_status.full) begin
               push     = 1'b1;
               state_in = FS_IDLE;
            end else begin
               state_in = FS_PUSH;
            end
         end
         FS_PUSH: begin
            if (!q_status.full) begin
               push     = 1'b1;
               state_in = FS_IDLE;
            end
         end
         default: begin
            state_in = FS_IDLE;
         end
      endcase

      push_data.finished = fin_ff;
      push_data.done     = done_sel;
      push_data.fill     = fill_ff;
      push_data.off_x    = pt_x_ff;
      push_data.off_y    = pt_y_ff;
      push_data.cen_x    = cen_x_ff;
      push_data.cen_y    = cen_y_ff;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= FS_IDLE;
         region_ff <= REG_FINISHED;
      end else begin
         state_ff  <= state_in;
         region_ff <= region_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      off_x_ff <= off_x_in;
      off_y_ff <= off_y_in;
      a_sq_ff  <= a_sq_in;
      b_sq_ff  <= b_sq_in;
      kdiff_ff <= kdiff_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      dec_ff   <= dec_in;
      cen_x_ff <= cen_x_in;
      cen_y_ff <= cen_y_in;
      fill_ff  <= fill_in;
      rad_x_ff <= rad_x_in;
      pt_x_ff  <= pt_x_in;
      pt_y_ff  <= pt_y_in;
      cond_ff  <= cond_in;
      step_ff  <= step_in;
      fin_ff   <= fin_in;
      done_ff  <= done_in;
   end

endmodule

[rtl/core/mer_queue.sv]
`include "midpoint_ellipse_rasterizer_core_macros.svh"

module mer_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  mer_pkg::point_type    push_data,
   input  logic                  pop,
   output mer_pkg::point_type    head,
   output mer_pkg::q_status_type status
);
   import mer_pkg::*;

   point_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]  count_ff, count_in;

   localparam logic [QPTR_BITS-1:0] PTR_TOP = QPTR_BITS'(QUEUE_DEPTH - 1);
   localparam logic [QCNT_BITS-1:0] CNT_TOP = QCNT_BITS'(QUEUE_DEPTH);

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_TOP) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_TOP) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
      status.full  = (count_ff == CNT_TOP);
      status.empty = (count_ff == '0);
      head         = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed point
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `MER_ASSERT_NEVER(a_count_range, clock, reset, count_ff > CNT_TOP, "queue count overrun")
   `MER_ASSERT_NEVER(a_push_full, clock, reset, push && status.full && !pop, "push into full queue")
   `MER_ASSERT_NEXT(a_pop_last, clock, reset, pop && !push && (count_ff == QCNT_BITS'(1)), status.empty, "queue not empty after last pop")

endmodule

[rtl/core/mer_back.sv]
module mer_back (
   input  logic                              clock,
   input  logic                              reset,
   input  mer_pkg::q_status_type             q_status,
   input  mer_pkg::point_type                head,
   output logic                              pop,
   output logic                              out_valid,
   input  logic                              out_ready,
   output mer_pkg::result_kind_type          result_kind,
   output logic signed [mer_pkg::OUT_BITS-1:0] left_x,
   output logic signed [mer_pkg::OUT_BITS-1:0] row_y,
   output logic signed [mer_pkg::OUT_BITS-1:0] right_x,
   output logic                              last,
   output logic                              done_res
);
   import mer_pkg::*;

   logic [1:0]                  idx_ff, idx_in;
   logic                        valid_ff, valid_in;
   result_kind_type             kind_ff, kind_in;
   logic signed [OUT_BITS-1:0]  left_ff, left_in;
   logic signed [OUT_BITS-1:0]  row_ff, row_in;
   logic signed [OUT_BITS-1:0]  right_ff, right_in;
   logic                        last_ff, last_in;
   logic                        done_ff, done_in;

   logic                        load, is_last;
   logic [1:0]                  idx_top;
   logic signed [OUT_BITS-1:0]  xe, ye, cxe, cye;
   logic signed [OUT_BITS-1:0]  plus_x, minus_x, plus_y, minus_y;

   // Mirror the point about the centre
   always_comb begin
      xe      = OUT_BITS'(signed'({1'b0, head.off_x}));
      ye      = OUT_BITS'(head.off_y);
      cxe     = OUT_BITS'(head.cen_x);
      cye     = OUT_BITS'(head.cen_y);
      plus_x  = cxe + xe;
      minus_x = cxe - xe;
      plus_y  = cye + ye;
      minus_y = cye - ye;
   end

   // Expand the head point into result words
   always_comb begin
      priority if (head.finished) begin
         idx_top = 2'd0;
      end else if (head.fill) begin
         idx_top = 2'd1;
      end else begin
         idx_top = 2'd3;
      end
      is_last = (idx_ff == idx_top);
      load    = !q_status.empty && (!valid_ff || out_ready);
      pop     = load && is_last;

      idx_in   = idx_ff;
      valid_in = valid_ff;
      kind_in  = kind_ff;
      left_in  = left_ff;
      row_in   = row_ff;
      right_in = right_ff;
      last_in  = last_ff;
      done_in  = done_ff;

      if (load) begin
         idx_in   = is_last ? 2'd0 : idx_ff + 2'd1;
         valid_in = 1'b1;
         last_in  = is_last;
         done_in  = is_last && head.done;
         priority if (head.finished) begin
            kind_in  = RK_NONE;
            left_in  = '0;
            row_in   = '0;
            right_in = '0;
         end else if (head.fill) begin
            kind_in  = RK_SPAN;
            left_in  = minus_x;
            right_in = plus_x;
            row_in   = idx_ff[0] ? minus_y : plus_y;
         end else begin
            kind_in  = RK_PIXEL;
            left_in  = idx_ff[0] ? minus_x : plus_x;
            right_in = idx_ff[0] ? minus_x : plus_x;
            row_in   = idx_ff[1] ? minus_y : plus_y;
         end
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Hold the output word until taken
   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      left_ff  <= left_in;
      row_ff   <= row_in;
      right_ff <= right_in;
      last_ff  <= last_in;
      done_ff  <= done_in;
   end

   assign out_valid   = valid_ff;
   assign result_kind = kind_ff;
   assign left_x      = left_ff;
   assign row_y       = row_ff;
   assign right_x     = right_ff;
   assign last        = last_ff;
   assign done_res    = done_ff;

endmodule

[rtl/core/midpoint_ellipse_rasterizer_core.sv]
// Channel   Direction  Handshake              Payload
// req_      in         req_tvalid/req_tready  tuser kind, tdata centre, radii, fill
// rsp_      out        rsp_tvalid/rsp_tready  tuser result kind, tlast, tdata coords, done
//
// A step word passes accept, offset update, decision update and region check; a start
// word passes accept, two radius multiplier steps, decision init and region check. Each
// drawn point gives 4 outline or 2 span words, registered, one per ready cycle.
// Up to 2 points wait in the queue, so the front runs on while the output is stalled.
// Reset leaves the ellipse finished; a step then yields one word marked done.
module midpoint_ellipse_rasterizer_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // kind
   input  logic                                  req_tuser,
   // center_x, center_y, radius_x, radius_y, fill, zero pad
   input  logic [mer_pkg::REQ_DATA_BITS-1:0]     req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // result_kind
   output logic [1:0]                            rsp_tuser,
   output logic                                  rsp_tlast,
   // left_x, row_y, right_x, done_res, zero pad
   output logic [mer_pkg::RSP_DATA_BITS-1:0]     rsp_tdata
);
   import mer_pkg::*;

   logic signed [COORD_BITS-1:0] center_x, center_y;
   logic [RADIUS_BITS-1:0]       radius_x, radius_y;
   logic                         fill;
   q_status_type                 q_status;
   point_type                    push_data, head;
   logic                         push, pop;
   result_kind_type              result_kind;
   logic signed [OUT_BITS-1:0]   left_x, row_y, right_x;
   logic                         done_res;

   // Unpack the request word
   always_comb begin
      center_x = req_tdata[COORD_BITS-1:0];
      center_y = req_tdata[2*COORD_BITS-1:COORD_BITS];
      radius_x = req_tdata[2*COORD_BITS+RADIUS_BITS-1:2*COORD_BITS];
      radius_y = req_tdata[2*COORD_BITS+2*RADIUS_BITS-1:2*COORD_BITS+RADIUS_BITS];
      fill     = req_tdata[2*COORD_BITS+2*RADIUS_BITS];
   end

   mer_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .kind      (req_tuser),
      .center_x  (center_x),
      .center_y  (center_y),
      .radius_x  (radius_x),
      .radius_y  (radius_y),
      .fill      (fill),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   mer_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   mer_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_status    (q_status),
      .head        (head),
      .pop         (pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .result_kind (result_kind),
      .left_x      (left_x),
      .row_y       (row_y),
      .right_x     (right_x),
      .last        (rsp_tlast),
      .done_res    (done_res)
   );

   // Pack the response word
   assign rsp_tuser = result_kind;
   assign rsp_tdata = {{RSP_PAD_BITS{1'b0}}, done_res, right_x, row_y, left_x};

endmodule
